### rtl/core/lnts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lnts_pkg
// Shared types and constants of the neuron table: command codes, status
// codes, field widths and the records passed between front, queue and back.
// ----------------------------------------------------------------------------
package lnts_pkg;

  localparam int unsigned IdxW  = 10;
  localparam int unsigned ThrW  = 16;
  localparam int unsigned TauW  = 16;
  localparam int unsigned CurW  = 24;
  localparam int unsigned DtW   = 16;
  localparam int unsigned PotW  = 48;
  localparam int unsigned ProdW = 64;

  typedef enum logic [1:0] {
    CMD_ALLOC = 2'd0,
    CMD_RESET = 2'd1,
    CMD_READ  = 2'd2,
    CMD_STEP  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_UNUSED = 2'd2
  } status_e;

  typedef struct packed {
    cmd_e             cmd;
    logic [IdxW-1:0]  idx;
    logic             in_range;
    logic [ThrW-1:0]  threshold;
    logic [TauW-1:0]  tau;
    logic [CurW-1:0]  current;
    logic [DtW-1:0]   dt;
  } op_t;

  typedef struct packed {
    logic             spike;
    logic [PotW-1:0]  pot;
    logic [IdxW-1:0]  handle;
    status_e          status;
  } res_t;

endpackage

### rtl/core/lnts_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lnts_front
// Unpack an input word into a command record and mark whether its index
// falls inside the table.
// ----------------------------------------------------------------------------
module lnts_front #(
  parameter int unsigned NEURONS = 1024
) (
  input  lnts_pkg::cmd_e  cmd_i,
  input  logic [87:0]     data_i,
  output lnts_pkg::op_t   op_o
);
  import lnts_pkg::*;

  logic [IdxW-1:0] idx;

  assign idx = data_i[9:0];

  always_comb begin
    op_o.cmd       = cmd_i;
    op_o.idx       = idx;
    op_o.in_range  = (32'(idx) < NEURONS);
    op_o.threshold = data_i[25:10];
    op_o.tau       = data_i[41:26];
    op_o.current   = data_i[65:42];
    op_o.dt        = data_i[81:66];
  end

endmodule

### rtl/core/lnts_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lnts_queue
// Two-entry command queue between the front and the back.
// ----------------------------------------------------------------------------
module lnts_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  lnts_pkg::op_t  op_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output lnts_pkg::op_t  op_o
);
  import lnts_pkg::*;

  op_t        slot_q [2];
  logic       wr_q, wr_d, rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign op_o    = slot_q[rd_q];

  always_comb begin
    wr_d  = wr_q ^ push_i;
    rd_d  = rd_q ^ pop_i;
    cnt_d = cnt_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= op_i;
    end
  end

endmodule

### rtl/core/lnts_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lnts_div
// Restoring divider: 64-bit unsigned dividend by a 16-bit divisor, one
// quotient bit per cycle.
// ----------------------------------------------------------------------------
module lnts_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] dividend_i,
  input  logic [15:0] divisor_i,
  output logic        done_o,
  output logic [63:0] quot_o
);
  logic [63:0] quo_q, quo_d;
  logic [15:0] rem_q, rem_d;
  logic [15:0] dvs_q;
  logic [6:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [16:0] trial;

  assign done_o = done_q;
  assign quot_o = quo_q;

  always_comb begin
    trial  = {rem_q, quo_q[63]};
    quo_d  = {quo_q[62:0], 1'b0};
    rem_d  = trial[15:0];
    if (trial >= {1'b0, dvs_q}) begin
      rem_d    = 16'(trial - {1'b0, dvs_q});
      quo_d[0] = 1'b1;
    end
    cnt_d  = cnt_q + 7'd1;
    busy_d = busy_q && (cnt_q != 7'd63);
    done_d = busy_q && (cnt_q == 7'd63);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 7'd0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= 7'd0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= busy_q ? cnt_d : cnt_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= 16'd0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

endmodule

### rtl/core/lnts_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lnts_back
// Execute queued commands against the neuron table and hold one result.
// ----------------------------------------------------------------------------
module lnts_back #(
  parameter int unsigned NEURONS = 1024
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           empty_i,
  input  lnts_pkg::op_t  op_i,
  output logic           pop_o,
  output logic           res_valid_o,
  input  logic           res_ready_i,
  output lnts_pkg::res_t res_o
);
  import lnts_pkg::*;

  localparam int unsigned AW = (NEURONS > 1) ? $clog2(NEURONS) : 1;
  localparam int unsigned CW = $clog2(NEURONS + 1);
  localparam logic signed [65:0] PotMax = 66'sh0_0000_7FFF_FFFF_FFFF;
  localparam logic signed [65:0] PotMin = -PotMax - 66'sd1;

  typedef enum logic [2:0] {
    S_IDLE, S_LOOK, S_EXEC, S_MUL, S_ABS, S_DIV, S_SUB, S_ADD
  } state_e;

  state_e state_q;
  op_t    op_q;
  logic   res_valid_q, res_valid_d;
  res_t   res_q, res_d;
  logic   issue;
  logic [CW-1:0] count_q;

  logic [PotW-1:0] pot_mem [NEURONS];
  logic [ThrW-1:0] thr_mem [NEURONS];
  logic [TauW-1:0] tau_mem [NEURONS];
  logic [PotW-1:0] pot_rd_q;
  logic [ThrW-1:0] thr_rd_q;
  logic [TauW-1:0] tau_rd_q;

  logic               we;
  logic [AW-1:0]      waddr;
  logic [PotW-1:0]    wdata;
  logic               alloc_we;

  logic signed [64:0] prod_q;
  logic               neg_q;
  logic [63:0]        quo_q;
  logic signed [65:0] diff_q;
  logic [63:0]        mag;
  logic               div_start;
  logic               div_done;
  logic [63:0]        div_quot;
  logic signed [65:0] qs, sum, level;
  logic               live, full, out_free;
  logic [AW-1:0]      raddr;

  assign raddr       = AW'(op_q.idx);
  assign full        = (count_q == CW'(NEURONS));
  assign live        = op_q.in_range && (CW'(op_q.idx) < count_q);
  assign out_free    = !res_valid_q || res_ready_i;
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;
  assign pop_o       = (state_q == S_IDLE) && !empty_i;
  assign mag         = prod_q[64] ? 64'(-prod_q) : prod_q[63:0];
  assign div_start   = (state_q == S_ABS);
  assign qs          = neg_q ? -$signed({2'b00, quo_q}) : $signed({2'b00, quo_q});
  assign sum         = diff_q + {{42{op_q.current[CurW-1]}}, op_q.current};
  assign level       = {{34{thr_rd_q[ThrW-1]}}, thr_rd_q, 16'h0000};

  lnts_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (mag),
    .divisor_i  (tau_rd_q),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  // table write port
  always_comb begin
    we       = 1'b0;
    alloc_we = 1'b0;
    waddr    = raddr;
    wdata    = '0;
    if (state_q == S_EXEC) begin
      unique case (op_q.cmd)
        CMD_ALLOC: begin
          alloc_we = !full;
          we       = !full;
          waddr    = AW'(count_q);
        end
        CMD_RESET: we = op_q.in_range;
        CMD_READ,
        CMD_STEP:  we = 1'b0;
        default:   we = 1'b0;
      endcase
    end else if (state_q == S_ADD && out_free) begin
      we = 1'b1;
      if (sum >= level) begin
        wdata = '0;
      end else if (sum > PotMax) begin
        wdata = PotMax[PotW-1:0];
      end else if (sum < PotMin) begin
        wdata = PotMin[PotW-1:0];
      end else begin
        wdata = sum[PotW-1:0];
      end
    end
  end

  // result word for the command that finishes this cycle
  always_comb begin
    issue = out_free && ((state_q == S_ADD) ||
            (state_q == S_EXEC && !(op_q.cmd == CMD_STEP && live)));
    res_valid_d = issue || (res_valid_q && !res_ready_i);
    res_d = '0;
    unique case (op_q.cmd)
      CMD_ALLOC: begin
        if (full) begin
          res_d.status = ST_FULL;
        end else begin
          res_d.handle = IdxW'(count_q);
        end
      end
      CMD_READ:  res_d.pot = live ? pot_rd_q : '0;
      CMD_STEP: begin
        if (state_q == S_ADD) begin
          res_d.spike = (sum >= level);
        end else begin
          res_d.status = ST_UNUSED;
        end
      end
      CMD_RESET: res_d.status = ST_OK;
      default:   res_d.status = ST_OK;
    endcase
  end

  always_ff @(posedge clk_i) begin
    pot_rd_q <= pot_mem[raddr];
    thr_rd_q <= thr_mem[raddr];
    tau_rd_q <= tau_mem[raddr];
    if (we) begin
      pot_mem[waddr] <= wdata;
    end
    if (alloc_we) begin
      thr_mem[waddr] <= op_q.threshold;
      tau_mem[waddr] <= op_q.tau;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      op_q <= op_i;
    end
    if (state_q == S_EXEC) begin
      quo_q <= '0;
      neg_q <= 1'b0;
      diff_q <= '0;
    end
    if (state_q == S_MUL) begin
      prod_q <= $signed(pot_rd_q) * $signed({1'b0, op_q.dt});
    end
    if (state_q == S_ABS) begin
      neg_q <= prod_q[64];
    end
    if (state_q == S_DIV && div_done) begin
      quo_q <= div_quot;
    end
    if (state_q == S_SUB) begin
      diff_q <= $signed({{18{pot_rd_q[PotW-1]}}, pot_rd_q}) - qs;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      res_valid_q <= 1'b0;
      res_q       <= '0;
      count_q     <= '0;
    end else begin
      res_valid_q <= res_valid_d;
      if (issue) begin
        res_q <= res_d;
      end
      unique case (state_q)
        S_IDLE: begin
          if (!empty_i) begin
            state_q <= S_LOOK;
          end
        end
        S_LOOK: state_q <= S_EXEC;
        S_EXEC: begin
          if (op_q.cmd == CMD_STEP && live) begin
            state_q <= (tau_rd_q == '0) ? S_SUB : S_MUL;
          end else if (out_free) begin
            state_q <= S_IDLE;
            if (op_q.cmd == CMD_ALLOC && !full) begin
              count_q <= count_q + CW'(1);
            end
          end
        end
        S_MUL: state_q <= S_ABS;
        S_ABS: state_q <= S_DIV;
        S_DIV: begin
          if (div_done) begin
            state_q <= S_SUB;
          end
        end
        S_SUB: state_q <= S_ADD;
        S_ADD: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

### rtl/core/lif_neuron_table_step_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lif_neuron_table_step_top
// Table of leaky integrate-and-fire neurons driven by a command stream.
// ----------------------------------------------------------------------------
// Each input word carries one command (allocate, reset potential, read
// potential, integrate one step) and yields exactly one output word. Commands
// enter a two-entry queue, so the input side keeps taking words while the
// executor works and while a result waits on the output register. Commands
// run one at a time. A step on a live neuron is paced by the bit-serial
// divider that forms v*dt/tau one quotient bit per cycle (a step with tau of
// zero skips the multiply and divide). Entries are handed out in order, so
// the in-use state is a single fill count and free entries always read a
// zero potential; no clearing pass follows reset.
module lif_neuron_table_step_top #(
  parameter int unsigned NEURONS = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // neuron[9:0], threshold[25:10], time_constant[41:26], current[65:42],
  // time_step[81:66], zero fill above
  input  logic [87:0] s_axis_tdata_i,
  // command[1:0]
  input  logic [1:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // spike[0], potential[48:1], new_handle[58:49], status[60:59], zero above
  output logic [63:0] m_axis_tdata_o
);
  import lnts_pkg::*;

  op_t  fr_op, q_op;
  res_t res;
  logic q_full, q_empty, q_pop, push;

  // accept whenever the queue has a free slot
  assign s_axis_tready_o = !q_full;
  assign push            = s_axis_tvalid_i && !q_full;

  lnts_front #(.NEURONS(NEURONS)) u_front (
    .cmd_i  (cmd_e'(s_axis_tuser_i)),
    .data_i (s_axis_tdata_i),
    .op_o   (fr_op)
  );

  lnts_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .op_i    (fr_op),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .op_o    (q_op)
  );

  lnts_back #(.NEURONS(NEURONS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (q_empty),
    .op_i        (q_op),
    .pop_o       (q_pop),
    .res_valid_o (m_axis_tvalid_o),
    .res_ready_i (m_axis_tready_i),
    .res_o       (res)
  );

  // pack the result word, lowest field first
  assign m_axis_tdata_o = {3'b000, res.status, res.handle, res.pot, res.spike};

endmodule
